### src/wfte_pkg.sv
package wfte_pkg;

    localparam int  TABLE_SLOTS_DEF = 16;
    localparam logic [15:0] LIFETIME_RESET = 16'd60;

    localparam logic KIND_CHECK = 1'b0;
    localparam logic KIND_ADD   = 1'b1;

    typedef struct packed {
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [7:0]  protocol;
        logic [15:0] src_port;
        logic [15:0] dst_port;
    } t_tuple;

    typedef struct packed {
        t_tuple      tuple;
        logic [31:0] expiry;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic match;
        logic expired;
    } t_cmp_res;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_FIN
    } t_state;

endpackage

### src/wfte_ram.sv
module wfte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/wfte_cmp.sv
module wfte_cmp
    import wfte_pkg::*;
(
    input  t_tuple      i_probe,
    input  logic [31:0] i_now,
    input  t_entry      i_entry,
    output t_cmp_res    o_res
);

    logic ok_sip;
    logic ok_dip;
    logic ok_pr;
    logic ok_sp;
    logic ok_dp;

    // A stored field of zero matches any probe value.
    assign ok_sip = (i_entry.tuple.src_ip == '0)   || (i_entry.tuple.src_ip == i_probe.src_ip);
    assign ok_dip = (i_entry.tuple.dst_ip == '0)   || (i_entry.tuple.dst_ip == i_probe.dst_ip);
    assign ok_pr  = (i_entry.tuple.protocol == '0) ||
                    (i_entry.tuple.protocol == i_probe.protocol);
    assign ok_sp  = (i_entry.tuple.src_port == '0) ||
                    (i_entry.tuple.src_port == i_probe.src_port);
    assign ok_dp  = (i_entry.tuple.dst_port == '0) ||
                    (i_entry.tuple.dst_port == i_probe.dst_port);

    assign o_res.match   = ok_sip && ok_dip && ok_pr && ok_sp && ok_dp;
    assign o_res.expired = (i_entry.expiry <= i_now);

endmodule

### src/wildcard_flow_table_with_expiry_unit.sv
// Flow table with wildcard fields and per-entry expiry for a stateful firewall.
// A command is transferred at a rising edge where start is high and busy is low.
// i_kind selects a check of the tuple or an add of a new flow entry, whose
// expiry is i_now_seconds plus the lifetime. Each command produces one
// result: o_granted, valid for exactly one cycle while o_done is high.
// The receiver cannot stall. A command walks the slot memory one slot per
// cycle through one shared compare unit and the states S_SCAN, S_LAST and
// S_FIN; o_done is registered from S_FIN. Busy drops as o_done rises, so
// a new command may be transferred in the cycle o_done is shown, but not
// before the previous command is done.
// The lifetime register is written through i_cfg_we and i_cfg_wdata; the user
// must write it only while idle (not enforced). It resets to 60 seconds.
// Reset empties the table by clearing the slot valid flags; the slot memory
// itself is not cleared and needs no clearing pass.
module wildcard_flow_table_with_expiry_unit
    import wfte_pkg::*;
#(
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_kind,
    input  logic [31:0] i_src_ip,
    input  logic [31:0] i_dst_ip,
    input  logic [7:0]  i_protocol,
    input  logic [15:0] i_src_port,
    input  logic [15:0] i_dst_port,
    input  logic [31:0] i_now_seconds,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    output logic        o_done,
    output logic        o_granted
);

    localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);

    t_state r_state;
    t_state n_state;

    logic [15:0]            r_life;
    logic                   r_kind;
    t_tuple                 r_probe;
    logic [31:0]            r_now;
    logic [31:0]            r_new_exp;
    logic [IDX_W-1:0]       r_cnt;
    logic [IDX_W-1:0]       r_pidx;
    logic                   r_pend;
    logic [TABLE_SLOTS-1:0] r_used;
    logic [TABLE_SLOTS-1:0] r_exp_mask;
    logic                   r_grant;
    logic                   r_free_found;
    logic [IDX_W-1:0]       r_free_idx;
    logic                   r_exp_found;
    logic [IDX_W-1:0]       r_exp_idx;
    logic                   r_done;
    logic                   r_granted;

    logic        accept;
    logic        scan;
    logic        eval;
    logic        fin;
    logic [32:0] exp_sum;
    logic        ram_we;
    logic [IDX_W-1:0] ram_waddr;
    t_entry      ram_wdata;
    t_entry      ram_rdata;
    t_cmp_res    cmp_res;

    assign accept  = start && !busy;
    assign exp_sum = {1'b0, i_now_seconds} + {17'b0, r_life};

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_cnt == LAST_IDX) begin
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        busy = 1'b1;
        scan = 1'b0;
        eval = 1'b0;
        fin  = 1'b0;
        case (r_state)
            S_IDLE: begin
                busy = 1'b0;
            end
            S_SCAN: begin
                scan = 1'b1;
                eval = r_pend;
            end
            S_LAST: begin
                eval = r_pend;
            end
            S_FIN: begin
                fin = 1'b1;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_free_idx;
        if (fin && (r_kind == KIND_ADD)) begin
            if (r_free_found) begin
                ram_we = 1'b1;
            end else if (r_exp_found) begin
                ram_we    = 1'b1;
                ram_waddr = r_exp_idx;
            end
        end
        ram_wdata.tuple  = r_probe;
        ram_wdata.expiry = r_new_exp;
    end

    wfte_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_SLOTS),
        .AW    (IDX_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_cnt),
        .o_rdata (ram_rdata)
    );

    wfte_cmp u_cmp (
        .i_probe (r_probe),
        .i_now   (r_now),
        .i_entry (ram_rdata),
        .o_res   (cmp_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_life  <= LIFETIME_RESET;
            r_used  <= '0;
            r_pend  <= 1'b0;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= fin;
            if (i_cfg_we) begin
                r_life <= i_cfg_wdata;
            end
            if (accept) begin
                r_cnt        <= '0;
                r_pend       <= 1'b0;
                r_grant      <= 1'b0;
                r_free_found <= 1'b0;
                r_exp_found  <= 1'b0;
                r_exp_mask   <= '0;
            end
            if (scan) begin
                r_pend <= 1'b1;
                r_pidx <= r_cnt;
                if (r_cnt != LAST_IDX) begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end else if (r_state == S_LAST) begin
                r_pend <= 1'b0;
            end
            if (eval) begin
                if (r_used[r_pidx]) begin
                    if (r_kind == KIND_CHECK) begin
                        if (cmp_res.match) begin
                            if (cmp_res.expired) begin
                                r_used[r_pidx] <= 1'b0;
                            end else begin
                                r_grant <= 1'b1;
                            end
                        end
                    end else if (cmp_res.expired) begin
                        r_exp_mask[r_pidx] <= 1'b1;
                        if (!r_exp_found) begin
                            r_exp_found <= 1'b1;
                            r_exp_idx   <= r_pidx;
                        end
                    end
                end else if ((r_kind == KIND_ADD) && !r_free_found) begin
                    r_free_found <= 1'b1;
                    r_free_idx   <= r_pidx;
                end
            end
            if (fin) begin
                r_cnt <= '0;
                if (r_kind == KIND_CHECK) begin
                    r_granted <= r_grant;
                end else if (r_free_found) begin
                    r_used[r_free_idx] <= 1'b1;
                    r_granted          <= 1'b1;
                end else if (r_exp_found) begin
                    // Full table: reclaim every expired slot, then take the lowest one.
                    r_used <= (r_used & ~r_exp_mask) |
                              (TABLE_SLOTS'(1) << r_exp_idx);
                    r_granted <= 1'b1;
                end else begin
                    r_granted <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind    <= i_kind;
            r_probe   <= '{i_src_ip, i_dst_ip, i_protocol, i_src_port, i_dst_port};
            r_now     <= i_now_seconds;
            r_new_exp <= exp_sum[32] ? 32'hFFFF_FFFF : exp_sum[31:0];
        end
    end

    assign o_done    = r_done;
    assign o_granted = r_granted;

`ifndef NO_ASSERTIONS
    a_done_after_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_state == S_FIN))
        else $error("result strobe without a finished scan");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !busy)
        else $error("result strobe while still busy");

    a_add_sets_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fin && (r_kind == KIND_ADD) && r_free_found) |=> r_used[$past(r_free_idx)])
        else $error("granted add left its slot unused");

    a_no_write_on_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (fin && (r_kind == KIND_ADD)))
        else $error("slot memory written outside an add");
`endif

endmodule
